// ===== sv/cmc_pkg.sv =====
package cmc_pkg;

    // Sizing of the member store
    localparam int MAX_POINTS = 64;
    localparam int DIMS       = 64;
    localparam int PIXEL_BITS = 16;

    // Fixed field widths of the request and result words
    localparam int REQ_W = 2;
    localparam int DIM_W = 6;
    localparam int VAL_W = 16;

    localparam int MEM_DEPTH = MAX_POINTS * DIMS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int COUNT_W   = $clog2(MAX_POINTS + 1);

    typedef logic [PIXEL_BITS-1:0] t_pix;
    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [COUNT_W-1:0]    t_count;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD  = 2'd0,
        REQ_QUERY = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    // Command into the selection engine
    typedef struct packed {
        logic   start;
        t_addr  base;
        t_count n;
    } t_sel_cmd;

    // Read request toward the store
    typedef struct packed {
        logic  en;
        t_addr addr;
    } t_rd_req;

    // Result out of the selection engine
    typedef struct packed {
        logic done;
        t_pix value;
    } t_sel_res;

    function automatic logic dim_ok(input logic [DIM_W-1:0] d);
        return (32'(d) < DIMS);
    endfunction

endpackage

// ===== sv/cmc_store.sv =====
module cmc_store
    import cmc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_wr_en,
    input  t_addr   i_wr_addr,
    input  t_pix    i_wr_data,
    input  t_rd_req i_rd,
    output t_pix    o_rd_data
);

    t_pix r_mem [MEM_DEPTH];
    t_pix r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/cmc_select.sv =====
module cmc_select
    import cmc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_sel_cmd i_cmd,
    output logic     o_busy,
    output t_rd_req  o_rd,
    input  t_pix     i_rd_data,
    output t_sel_res o_res
);

    // One result bit per pass over the stored column, most significant first
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SWEEP  = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_DECIDE = 4'b1000
    } t_sel_state;

    t_sel_state r_state, n_state;
    logic       r_rd_vld, n_rd_vld;
    t_addr      r_base, n_base;
    t_addr      r_addr, n_addr;
    t_count     r_idx, n_idx;
    t_count     r_n, n_n;
    t_count     r_k, n_k;
    t_count     r_cnt0, n_cnt0;
    t_pix       r_prefix, n_prefix;
    t_pix       r_mask, n_mask;
    t_pix       r_bit, n_bit;

    logic       match;
    logic       bit_zero;
    logic       take_one;

    assign match    = ((i_rd_data ^ r_prefix) & r_mask) == '0;
    assign bit_zero = (i_rd_data & r_bit) == '0;
    assign take_one = !(r_k < r_cnt0);

    always_comb begin
        n_state  = r_state;
        n_base   = r_base;
        n_addr   = r_addr;
        n_idx    = r_idx;
        n_n      = r_n;
        n_k      = r_k;
        n_cnt0   = r_cnt0;
        n_prefix = r_prefix;
        n_mask   = r_mask;
        n_bit    = r_bit;
        n_rd_vld = (r_state == S_SWEEP);

        // count candidates that still share the prefix and hold a zero here
        if (r_rd_vld && match && bit_zero) begin
            n_cnt0 = r_cnt0 + 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_base   = i_cmd.base;
                    n_addr   = i_cmd.base;
                    n_idx    = '0;
                    n_n      = i_cmd.n;
                    n_k      = i_cmd.n >> 1;
                    n_cnt0   = '0;
                    n_prefix = '0;
                    n_mask   = '0;
                    n_bit    = {1'b1, {(PIXEL_BITS-1){1'b0}}};
                    n_state  = S_SWEEP;
                end
            end
            S_SWEEP: begin
                n_addr = r_addr + ADDR_W'(DIMS);
                n_idx  = r_idx + 1'b1;
                if (r_idx == r_n - 1'b1) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (take_one) begin
                    n_prefix = r_prefix | r_bit;
                    n_k      = r_k - r_cnt0;
                end
                n_mask = r_mask | r_bit;
                n_bit  = r_bit >> 1;
                if (r_bit[0]) begin
                    n_state = S_IDLE;
                end else begin
                    n_addr  = r_base;
                    n_idx   = '0;
                    n_cnt0  = '0;
                    n_state = S_SWEEP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base   <= n_base;
        r_addr   <= n_addr;
        r_idx    <= n_idx;
        r_n      <= n_n;
        r_k      <= n_k;
        r_cnt0   <= n_cnt0;
        r_prefix <= n_prefix;
        r_mask   <= n_mask;
        r_bit    <= n_bit;
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_rd.en    = (r_state == S_SWEEP);
    assign o_rd.addr  = r_addr;
    assign o_res.done  = (r_state == S_DECIDE) && r_bit[0];
    assign o_res.value = take_one ? (r_prefix | r_bit) : r_prefix;

endmodule

// ===== sv/coordinate_median_centroid.sv =====
// Coordinate-wise median store for one k-medians cluster. A word is taken
// at a clock edge where start is high and busy is low. A load word writes
// one pixel of the point being filled; with i_end_of_point set it appends
// that point (ignored once the set is full). A clear word empties the set,
// leaving the stored pixels in place. A query word answers the value of
// rank floor(n/2) of the asked dimension among the n stored points, shown
// on the result ports for one cycle with o_valid high; the receiver cannot
// hold it off, so take it then. A query on an empty set or on a dimension
// beyond the store answers the cycle after it is taken. Any other query
// walks the stored column once for each pixel bit through the single read
// port of the store, fixing one result bit per pass from the top: busy
// stays high while the engine works, and the result shows in the cycle
// right after the last busy one, with busy already low.
// Request type 3 is dropped. The store needs no clearing after reset.
module coordinate_median_centroid
    import cmc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [REQ_W-1:0] i_req_type,
    input  logic [DIM_W-1:0] i_dim_index,
    input  logic [VAL_W-1:0] i_pixel_value,
    input  logic             i_end_of_point,
    output logic             o_valid,
    output logic [VAL_W-1:0] o_median_value,
    output logic [DIM_W-1:0] o_dim_echo,
    output logic             o_set_empty
);

    logic       accept;
    logic       is_load;
    logic       is_query;
    logic       is_clear;
    logic       dim_in;
    logic       full;
    logic       wr_en;
    t_addr      wr_addr;

    t_sel_cmd   sel_cmd;
    t_sel_res   sel_res;
    t_rd_req    rd_req;
    t_pix       rd_data;
    logic       sel_busy;

    // Control state
    t_count     r_count, n_count;
    t_addr      r_row_base, n_row_base;
    logic       r_valid, n_valid;

    // Result word and the dimension of the query in flight
    logic [VAL_W-1:0] r_median, n_median;
    logic [DIM_W-1:0] r_dim_echo, n_dim_echo;
    logic             r_empty, n_empty;
    logic [DIM_W-1:0] r_qdim, n_qdim;

    assign accept   = start && !busy;
    assign is_load  = (i_req_type == REQ_LOAD);
    assign is_query = (i_req_type == REQ_QUERY);
    assign is_clear = (i_req_type == REQ_CLEAR);
    assign dim_in   = dim_ok(i_dim_index);
    assign full     = (32'(r_count) >= MAX_POINTS);

    // Write the pixel into the row just past the stored points
    assign wr_en   = accept && is_load && !full && dim_in;
    assign wr_addr = r_row_base + ADDR_W'(i_dim_index);

    // Hand a query to the engine only when there is something to rank
    assign sel_cmd.start = accept && is_query && (r_count != '0) && dim_in;
    assign sel_cmd.base  = ADDR_W'(i_dim_index);
    assign sel_cmd.n     = r_count;

    always_comb begin
        n_count    = r_count;
        n_row_base = r_row_base;
        n_valid    = 1'b0;
        n_median   = r_median;
        n_dim_echo = r_dim_echo;
        n_empty    = r_empty;
        n_qdim     = r_qdim;

        if (accept) begin
            priority if (is_load) begin
                // append the point; advance the row base with it
                if (!full && i_end_of_point) begin
                    n_count    = r_count + 1'b1;
                    n_row_base = r_row_base + ADDR_W'(DIMS);
                end
            end else if (is_clear) begin
                n_count    = '0;
                n_row_base = '0;
            end else if (is_query) begin
                n_qdim = i_dim_index;
                if (!sel_cmd.start) begin
                    // empty set or dimension beyond the store: answer now
                    n_valid    = 1'b1;
                    n_median   = '0;
                    n_dim_echo = i_dim_index;
                    n_empty    = (r_count == '0);
                end
            end else begin
                // unused request type: drop
                n_count = r_count;
            end
        end

        if (sel_res.done) begin
            n_valid    = 1'b1;
            n_median   = VAL_W'(sel_res.value);
            n_dim_echo = r_qdim;
            n_empty    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_row_base <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_row_base <= n_row_base;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_median   <= n_median;
        r_dim_echo <= n_dim_echo;
        r_empty    <= n_empty;
        r_qdim     <= n_qdim;
    end

    cmc_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_pixel_value[PIXEL_BITS-1:0]),
        .i_rd      (rd_req),
        .o_rd_data (rd_data)
    );

    cmc_select u_select (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (sel_cmd),
        .o_busy    (sel_busy),
        .o_rd      (rd_req),
        .i_rd_data (rd_data),
        .o_res     (sel_res)
    );

    assign busy           = sel_busy;
    assign o_valid        = r_valid;
    assign o_median_value = r_median;
    assign o_dim_echo     = r_dim_echo;
    assign o_set_empty    = r_empty;

endmodule

// ===== sv/cmc_checker.sv =====
module cmc_checker
    import cmc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic [REQ_W-1:0] i_req_type,
    input logic             o_valid,
    input logic [VAL_W-1:0] o_median_value,
    input logic             o_set_empty
);

    // An empty answer carries a zero median
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_set_empty |-> o_median_value == '0)
        else $error("empty answer with nonzero median");

    // Loads, clears and dropped words never cause a result
    a_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_req_type != REQ_QUERY |=> !o_valid)
        else $error("result without a query");

    // A taken query either answers at once or occupies the engine
    a_query_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_req_type == REQ_QUERY |=> busy || o_valid)
        else $error("query lost");

    // The engine releases busy exactly when it shows its answer
    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(busy) |-> o_valid)
        else $error("engine finished without a result");

    // A result never shows while the engine still works
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result while busy");

endmodule

bind coordinate_median_centroid cmc_checker u_cmc_checker (.*);
